FILE: design/cll_pkg.sv
`default_nettype none

package cll_pkg;

  // List geometry
  localparam int DEPTH     = 16;
  localparam int KEY_BITS  = 16;
  localparam int SLOT_BITS = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  // Operation codes
  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [1:0] OP_REMOVE     = 2'd2;
  localparam logic [1:0] OP_DUMP       = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] key_number;
    logic [7:0]  passenger;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] entry_number;
    logic [7:0]  entry_passenger;
    logic [4:0]  count;
    logic        last;
  } out_item_t;

  // Datapath action selected by the current control word
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_INS_SLOT,
    ACT_INS_LINK,
    ACT_INS_COMMIT,
    ACT_WALK,
    ACT_UNLINK
  } act_t;

  // Result item written by the current control word
  typedef enum logic [2:0] {
    EM_NONE,
    EM_OK,
    EM_FULL,
    EM_NOT_FOUND,
    EM_EMPTY,
    EM_ENTRY
  } emit_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic full;
    logic empty;
    logic match;
    logic at_end;
    logic out_busy;
  } flags_t;

  // Sequencer controls handed to the datapath
  typedef struct packed {
    act_t  act;
    emit_t emit;
    logic  go;
    logic  taken;
    logic  idle;
  } ctl_t;

endpackage

`default_nettype wire

FILE: design/cll_seq.sv
`default_nettype none

module cll_seq (
  input  logic             clk,
  input  logic             rst,
  input  cll_pkg::flags_t  flags,
  input  logic [1:0]       op,
  output cll_pkg::ctl_t    ctl
);
  import cll_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH_CHK,
    S_PUSH_SLOT,
    S_PUSH_LINK,
    S_PUSH_DONE,
    S_REM_CHK,
    S_REM_SCAN,
    S_REM_TEST,
    S_REM_UNLINK,
    S_DUMP_CHK,
    S_DUMP_EMIT,
    S_EMPTY,
    S_NOT_FOUND,
    S_FULL
  } step_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_FULL,
    C_EMPTY,
    C_HIT_OR_END,
    C_MATCH,
    C_END
  } cond_t;

  typedef struct packed {
    act_t  act;
    emit_t emit;
    cond_t cond;
    logic  disp;
    step_t jt;
    step_t jf;
  } uword_t;

  // Control store: condition true goes to jt (or the op entry point), false to jf
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    case (s)
      S_IDLE:       w = '{ACT_LOAD,       EM_NONE,      C_IN_VALID,   1'b1, S_IDLE,       S_IDLE};
      S_PUSH_CHK:   w = '{ACT_NONE,       EM_NONE,      C_FULL,       1'b0, S_FULL,       S_PUSH_SLOT};
      S_PUSH_SLOT:  w = '{ACT_INS_SLOT,   EM_NONE,      C_EMPTY,      1'b0, S_PUSH_DONE,  S_PUSH_LINK};
      S_PUSH_LINK:  w = '{ACT_INS_LINK,   EM_NONE,      C_ALWAYS,     1'b0, S_PUSH_DONE,  S_PUSH_DONE};
      S_PUSH_DONE:  w = '{ACT_INS_COMMIT, EM_OK,        C_ALWAYS,     1'b0, S_IDLE,       S_IDLE};
      S_REM_CHK:    w = '{ACT_NONE,       EM_NONE,      C_EMPTY,      1'b0, S_EMPTY,      S_REM_SCAN};
      S_REM_SCAN:   w = '{ACT_WALK,       EM_NONE,      C_HIT_OR_END, 1'b0, S_REM_TEST,   S_REM_SCAN};
      S_REM_TEST:   w = '{ACT_NONE,       EM_NONE,      C_MATCH,      1'b0, S_REM_UNLINK, S_NOT_FOUND};
      S_REM_UNLINK: w = '{ACT_UNLINK,     EM_OK,        C_ALWAYS,     1'b0, S_IDLE,       S_IDLE};
      S_DUMP_CHK:   w = '{ACT_NONE,       EM_NONE,      C_EMPTY,      1'b0, S_EMPTY,      S_DUMP_EMIT};
      S_DUMP_EMIT:  w = '{ACT_WALK,       EM_ENTRY,     C_END,        1'b0, S_IDLE,       S_DUMP_EMIT};
      S_EMPTY:      w = '{ACT_NONE,       EM_EMPTY,     C_ALWAYS,     1'b0, S_IDLE,       S_IDLE};
      S_NOT_FOUND:  w = '{ACT_NONE,       EM_NOT_FOUND, C_ALWAYS,     1'b0, S_IDLE,       S_IDLE};
      S_FULL:       w = '{ACT_NONE,       EM_FULL,      C_ALWAYS,     1'b0, S_IDLE,       S_IDLE};
      default:      w = '{ACT_NONE,       EM_NONE,      C_ALWAYS,     1'b0, S_IDLE,       S_IDLE};
    endcase
    return w;
  endfunction

  // Entry point of each operation's routine
  function automatic step_t entry_step(input logic [1:0] code);
    step_t s;
    case (code)
      OP_PUSH_FRONT, OP_PUSH_BACK: s = S_PUSH_CHK;
      OP_REMOVE:                   s = S_REM_CHK;
      OP_DUMP:                     s = S_DUMP_CHK;
      default:                     s = S_IDLE;
    endcase
    return s;
  endfunction

  step_t  upc;
  step_t  upc_next;
  uword_t word;
  logic   cond_true;
  logic   go;

  assign word = ucode(upc);

  // Evaluate the branch condition of this step
  always_comb begin
    case (word.cond)
      C_ALWAYS:     cond_true = 1'b1;
      C_IN_VALID:   cond_true = flags.in_valid;
      C_FULL:       cond_true = flags.full;
      C_EMPTY:      cond_true = flags.empty;
      C_HIT_OR_END: cond_true = flags.match || flags.at_end;
      C_MATCH:      cond_true = flags.match;
      C_END:        cond_true = flags.at_end;
      default:      cond_true = 1'b0;
    endcase
  end

  // Hold a step that writes an item while the output register is still full
  assign go = (word.emit == EM_NONE) || !flags.out_busy;

  always_comb begin
    if (!go) begin
      upc_next = upc;
    end else if (cond_true) begin
      upc_next = word.disp ? entry_step(op) : word.jt;
    end else begin
      upc_next = word.jf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  assign ctl = '{act: word.act, emit: word.emit, go: go, taken: cond_true,
                 idle: (upc == S_IDLE)};

endmodule

`default_nettype wire

FILE: design/circular_list_with_key_removal_core.sv
`default_nettype none

// Circular doubly linked list of up to 16 entries (key and passenger byte).
// Input channel in_valid/in_ready/in_data carries one operation per item:
// push front, push back, remove by key, or dump. Output channel
// out_valid/out_ready/out_data returns one result item per push or remove,
// and one item per held entry (head to tail, last set on the tail) for a dump,
// or one empty-status item if the list is empty. An item is taken only while
// the sequencer sits in its idle step; it then runs the operation's microcode
// routine, one step per cycle unless a step that writes a result holds:
//   push:   report a full list, else write key and passenger to the lowest free
//           slot, link it in unless the list is empty, then commit and report.
//   remove: report an empty list, else walk from the head to a key match or the
//           tail, then unlink the match or report the key not found.
//   dump:   report an empty list, else write one entry per step up to the tail.
// The link walk reads one slot per step from the link memory, which sets the
// remove and dump time. Results pass through one output register; while the
// receiver stalls, the step that writes the next result holds, and a new
// item is accepted as soon as the routine ends even if its last result waits.
// Reset empties the list (all slots free, head, tail and count zero), drops
// any pending result and holds in_ready low; slot storage is not cleared.
module circular_list_with_key_removal_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cll_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cll_pkg::out_item_t  out_data
);
  import cll_pkg::*;

  // Slot storage
  logic [KEY_BITS-1:0]  slot_key     [DEPTH];
  logic [7:0]           slot_payload [DEPTH];
  logic [SLOT_BITS-1:0] next_link    [DEPTH];
  logic [SLOT_BITS-1:0] prev_link    [DEPTH];

  // Registered reads of the slot under the walk pointer
  logic [KEY_BITS-1:0]  rd_key;
  logic [7:0]           rd_pay;
  logic [SLOT_BITS-1:0] rd_next;
  logic [SLOT_BITS-1:0] rd_prev;

  // List state
  logic [DEPTH-1:0]     free_map;
  logic [DEPTH-1:0]     free_map_next;
  logic [SLOT_BITS-1:0] head;
  logic [SLOT_BITS-1:0] head_next;
  logic [SLOT_BITS-1:0] tail;
  logic [SLOT_BITS-1:0] tail_next;
  logic [CNT_BITS-1:0]  total;
  logic [CNT_BITS-1:0]  total_next;

  // Request and walk registers
  logic [1:0]           req_op;
  logic [KEY_BITS-1:0]  req_key;
  logic [7:0]           req_pay;
  logic [SLOT_BITS-1:0] cur;
  logic [SLOT_BITS-1:0] cur_next;
  logic [CNT_BITS-1:0]  idx;

  logic [SLOT_BITS-1:0] free_slot;
  logic                 is_empty;
  logic                 is_full;
  logic                 match;
  logic                 at_end;

  flags_t               flags;
  ctl_t                 ctl;
  act_t                 act;
  logic                 load;
  logic                 walk;

  logic                 key_we;
  logic                 next_we;
  logic [SLOT_BITS-1:0] next_wa;
  logic [SLOT_BITS-1:0] next_wd;
  logic                 prev_we;
  logic [SLOT_BITS-1:0] prev_wa;
  logic [SLOT_BITS-1:0] prev_wd;

  // Sequencer
  cll_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .op    (in_data.op),
    .ctl   (ctl)
  );

  assign in_ready = ctl.idle && !rst;

  // Status flags
  assign is_empty = (total == '0);
  assign is_full  = (total == CNT_BITS'(DEPTH));
  assign match    = (rd_key == req_key);
  assign at_end   = (CNT_BITS'(idx + 1'b1) == total);

  assign flags = '{in_valid: in_valid, full: is_full, empty: is_empty, match: match,
                   at_end: at_end, out_busy: out_valid && !out_ready};

  assign act  = ctl.go ? ctl.act : ACT_NONE;
  assign load = (act == ACT_LOAD) && ctl.taken;
  assign walk = (act == ACT_WALK) && !ctl.taken;

  // Pick the lowest free slot
  always_comb begin
    free_slot = '0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (free_map[k]) free_slot = SLOT_BITS'(k);
    end
  end

  // Advance the walk pointer; reads follow its next value
  always_comb begin
    if (load) begin
      cur_next = head;
    end else if (walk) begin
      cur_next = rd_next;
    end else begin
      cur_next = cur;
    end
  end

  // Link write decode
  always_comb begin
    key_we  = (act == ACT_INS_SLOT);
    next_we = 1'b0;
    next_wa = free_slot;
    next_wd = head;
    prev_we = 1'b0;
    prev_wa = free_slot;
    prev_wd = tail;
    case (act)
      ACT_INS_SLOT: begin
        next_we = 1'b1;
        prev_we = 1'b1;
        next_wd = is_empty ? free_slot : head;
        prev_wd = is_empty ? free_slot : tail;
      end
      ACT_INS_LINK: begin
        next_we = 1'b1;
        next_wa = tail;
        next_wd = free_slot;
        prev_we = 1'b1;
        prev_wa = head;
        prev_wd = free_slot;
      end
      ACT_UNLINK: begin
        next_we = (total != CNT_BITS'(1));
        next_wa = rd_prev;
        next_wd = rd_next;
        prev_we = (total != CNT_BITS'(1));
        prev_wa = rd_next;
        prev_wd = rd_prev;
      end
      default: begin
      end
    endcase
  end

  // Slot memories
  always_ff @(posedge clk) begin
    if (key_we) begin
      slot_key[free_slot]     <= req_key;
      slot_payload[free_slot] <= req_pay;
    end
    if (next_we) next_link[next_wa] <= next_wd;
    if (prev_we) prev_link[prev_wa] <= prev_wd;
    rd_key  <= slot_key[cur_next];
    rd_pay  <= slot_payload[cur_next];
    rd_next <= next_link[cur_next];
    rd_prev <= prev_link[cur_next];
  end

  // Commit list pointers, count and free map
  always_comb begin
    free_map_next = free_map;
    head_next     = head;
    tail_next     = tail;
    total_next    = total;
    case (act)
      ACT_INS_COMMIT: begin
        free_map_next[free_slot] = 1'b0;
        total_next = CNT_BITS'(total + 1'b1);
        if (is_empty) begin
          head_next = free_slot;
          tail_next = free_slot;
        end else if (req_op == OP_PUSH_FRONT) begin
          head_next = free_slot;
        end else begin
          tail_next = free_slot;
        end
      end
      ACT_UNLINK: begin
        free_map_next[cur] = 1'b1;
        total_next = CNT_BITS'(total - 1'b1);
        if (total == CNT_BITS'(1)) begin
          head_next = '0;
          tail_next = '0;
        end else begin
          if (cur == head) head_next = rd_next;
          if (cur == tail) tail_next = rd_prev;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_map <= '1;
      head     <= '0;
      tail     <= '0;
      total    <= '0;
    end else begin
      free_map <= free_map_next;
      head     <= head_next;
      tail     <= tail_next;
      total    <= total_next;
    end
  end

  // Capture the request, advance the walk
  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (load) begin
      req_op  <= in_data.op;
      req_key <= KEY_BITS'(in_data.key_number);
      req_pay <= in_data.passenger;
      idx     <= '0;
    end else if (walk) begin
      idx <= CNT_BITS'(idx + 1'b1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.go && ctl.emit != EM_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go && ctl.emit != EM_NONE) begin
      out_data.entry_number    <= (ctl.emit == EM_ENTRY) ? 16'(rd_key) : '0;
      out_data.entry_passenger <= (ctl.emit == EM_ENTRY) ? rd_pay : '0;
      out_data.count           <= 5'(total_next);
      out_data.last            <= (ctl.emit == EM_ENTRY) ? at_end : 1'b1;
      case (ctl.emit)
        EM_OK:        out_data.status <= ST_OK;
        EM_FULL:      out_data.status <= ST_FULL;
        EM_NOT_FOUND: out_data.status <= ST_NOT_FOUND;
        EM_EMPTY:     out_data.status <= ST_EMPTY;
        EM_ENTRY:     out_data.status <= ST_OK;
        default:      out_data.status <= ST_OK;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_free_count: assert property (@(posedge clk) disable iff (rst)
    ($countones(free_map) + int'(total)) == DEPTH)
    else $error("free map and entry count disagree");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (total == '0) |-> (head == '0 && tail == '0))
    else $error("empty list with nonzero head or tail");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while an operation runs");
`endif

endmodule

`default_nettype wire
